// ===== design/agam_pkg.sv =====
`default_nettype none

package agam_pkg;

   localparam int CHANNELS   = 8;
   localparam int SAMPLE_W   = 16;
   localparam int COUNT_W    = 4;
   localparam int SHIFT_W    = 4;
   localparam int IDX_W      = $clog2(CHANNELS);
   localparam int SUM_W      = SAMPLE_W + $clog2(CHANNELS);
   localparam int MAG_W      = SUM_W;
   localparam int LIMIT_W    = SAMPLE_W;

   localparam logic [LIMIT_W-1:0] OUT_MAX     = 16'h7FFF;
   localparam logic [LIMIT_W-1:0] OUT_MIN_MAG = 16'h8000;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MAG,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_UPDATE,
      ST_DONE
   } agam_state_type;

   typedef struct packed {
      logic req_valid;
      logic sum_last;
      logic clip_now;
      logic div_done;
      logic out_free;
   } agam_stat_type;

   typedef struct packed {
      logic accept;
      logic sum_en;
      logic mag_en;
      logic mul_en;
      logic check_en;
      logic div_start;
      logic gain_div_load;
      logic gain_update;
      logic out_load;
   } agam_ctrl_type;

endpackage

`default_nettype wire

// ===== design/agam_div.sv =====
`default_nettype none

module agam_div
   import agam_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [LIMIT_W-1:0]   limit,
   input  wire logic [MAG_W-1:0]     divisor,
   output logic                      done,
   output logic [FRAC_BITS-1:0]      quotient
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic [MAG_W:0]         rem_ff, rem_in;
   logic [MAG_W-1:0]       div_ff, div_in;
   logic [FRAC_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [MAG_W:0]         trial;
   logic                   fits;

   always_comb begin
      trial   = {rem_ff[MAG_W-1:0], 1'b0};
      fits    = trial >= {1'b0, div_ff};
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = (MAG_W + 1)'(limit);
         div_in  = divisor;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, div_ff}) : trial;
         quo_in = {quo_ff[FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/agam_ctrl.sv =====
`default_nettype none

module agam_ctrl
   import agam_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire agam_stat_type  stat,
   output logic                busy,
   output agam_ctrl_type       ctrl
);

   agam_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (stat.req_valid) state_in = ST_SUM;
         ST_SUM:    if (stat.sum_last) state_in = ST_MAG;
         ST_MAG:    state_in = ST_MUL;
         ST_MUL:    state_in = ST_CHECK;
         ST_CHECK:  state_in = stat.clip_now ? ST_DIV : ST_UPDATE;
         ST_DIV:    if (stat.div_done) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DONE;
         ST_DONE:   if (stat.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            ctrl.accept = stat.req_valid;
         end
         ST_SUM:    ctrl.sum_en = 1'b1;
         ST_MAG:    ctrl.mag_en = 1'b1;
         ST_MUL:    ctrl.mul_en = 1'b1;
         ST_CHECK: begin
            ctrl.check_en  = 1'b1;
            ctrl.div_start = stat.clip_now;
         end
         ST_DIV:    ctrl.gain_div_load = stat.div_done;
         ST_UPDATE: ctrl.gain_update = 1'b1;
         ST_DONE:   ctrl.out_load = stat.out_free;
         default:   ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/adaptive_gain_audio_mixer.sv =====
`default_nettype none

// Channel  Handshake               Payload
// req      req_valid / req_stall   req_ch0..7_sample, req_channel_count, req_frame_end
// rsp      rsp_valid / rsp_stall   rsp_mixed_sample, rsp_clipped
// csr      csr_write_en            csr_write_data (recovery shift)
//
// One item at a time: an accepted item steps through the sum, magnitude, multiply
// and check states, the restoring gain divider when the sample clips, gain update
// and the output register; the channel sum takes one channel per cycle, the divider one
// quotient bit per cycle. Synchronous reset sets gain to one and recovery shift to 6.
// A stalled result holds in the output register while the next item is accepted.

module adaptive_gain_audio_mixer
   import agam_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [SAMPLE_W-1:0]  req_ch0_sample,
   input  wire logic signed [SAMPLE_W-1:0]  req_ch1_sample,
   input  wire logic signed [SAMPLE_W-1:0]  req_ch2_sample,
   input  wire logic signed [SAMPLE_W-1:0]  req_ch3_sample,
   input  wire logic signed [SAMPLE_W-1:0]  req_ch4_sample,
   input  wire logic signed [SAMPLE_W-1:0]  req_ch5_sample,
   input  wire logic signed [SAMPLE_W-1:0]  req_ch6_sample,
   input  wire logic signed [SAMPLE_W-1:0]  req_ch7_sample,
   input  wire logic [COUNT_W-1:0]          req_channel_count,
   input  wire logic                        req_frame_end,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]       rsp_mixed_sample,
   output logic                             rsp_clipped,
   input  wire logic                        csr_write_en,
   input  wire logic [SHIFT_W-1:0]          csr_write_data
);

   localparam int GAIN_W = GAIN_FRAC_BITS + 1;
   localparam int PROD_W = MAG_W + GAIN_W;
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;

   agam_stat_type stat;
   agam_ctrl_type ctrl;
   logic          busy;

   logic signed [SAMPLE_W-1:0] samp_ff [CHANNELS];
   logic [COUNT_W-1:0]         count_ff;
   logic                       last_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic signed [SUM_W-1:0]    acc_ff, acc_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       neg_ff;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic [SHIFT_W-1:0]         shift_ff;
   logic signed [SAMPLE_W-1:0] result_ff, result_in;
   logic                       clip_ff;
   logic [LIMIT_W-1:0]         limit;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_clip_ff;
   logic                       rsp_valid_ff;

   logic signed [SAMPLE_W-1:0] pick;
   logic [MAG_W-1:0]           scaled;
   logic                       clip_now;
   logic [GAIN_W-1:0]          gain_diff;
   logic [GAIN_FRAC_BITS-1:0]  quotient;
   logic                       div_done;

   agam_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   agam_div #(
      .FRAC_BITS (GAIN_FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .limit    (limit),
      .divisor  (scaled),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      pick   = ({1'b0, idx_ff} < (IDX_W + 1)'(count_ff) || count_ff > COUNT_W'(CHANNELS))
               ? samp_ff[idx_ff] : '0;
      acc_in = acc_ff + SUM_W'(pick);
      mag_in = acc_ff[SUM_W-1] ? MAG_W'(-acc_ff) : MAG_W'(acc_ff);
      prod_in = PROD_W'(mag_ff) * PROD_W'(gain_ff);
      scaled = prod_ff[GAIN_FRAC_BITS +: MAG_W];
      limit  = neg_ff ? OUT_MIN_MAG : OUT_MAX;
      clip_now = scaled > MAG_W'(limit);
      if (clip_now) begin
         result_in = neg_ff ? signed'(OUT_MIN_MAG) : signed'(OUT_MAX);
      end else begin
         result_in = neg_ff ? -signed'(scaled[SAMPLE_W-1:0]) : signed'(scaled[SAMPLE_W-1:0]);
      end
      gain_diff = GAIN_ONE - gain_ff;
      gain_in   = gain_ff;
      if (gain_ff < GAIN_ONE) begin
         gain_in = gain_ff + (gain_diff >> shift_ff);
      end
      if (last_ff) begin
         gain_in = GAIN_ONE;
      end
   end

   always_comb begin
      stat.req_valid = req_valid;
      stat.sum_last  = idx_ff == IDX_W'(CHANNELS - 1);
      stat.clip_now  = clip_now;
      stat.div_done  = div_done;
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_ONE;
         shift_ff     <= SHIFT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            shift_ff <= csr_write_data;
         end
         if (ctrl.gain_div_load) begin
            gain_ff <= GAIN_W'(quotient);
         end else if (ctrl.gain_update) begin
            gain_ff <= gain_in;
         end
         if (ctrl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         samp_ff[0] <= req_ch0_sample;
         samp_ff[1] <= req_ch1_sample;
         samp_ff[2] <= req_ch2_sample;
         samp_ff[3] <= req_ch3_sample;
         samp_ff[4] <= req_ch4_sample;
         samp_ff[5] <= req_ch5_sample;
         samp_ff[6] <= req_ch6_sample;
         samp_ff[7] <= req_ch7_sample;
         count_ff   <= req_channel_count;
         last_ff    <= req_frame_end;
         idx_ff     <= '0;
         acc_ff     <= '0;
      end
      if (ctrl.sum_en) begin
         acc_ff <= acc_in;
         idx_ff <= idx_ff + 1'b1;
      end
      if (ctrl.mag_en) begin
         mag_ff <= mag_in;
         neg_ff <= acc_ff[SUM_W-1];
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.check_en) begin
         result_ff <= result_in;
         clip_ff   <= clip_now;
      end
      if (ctrl.out_load) begin
         rsp_sample_ff <= result_ff;
         rsp_clip_ff   <= clip_ff;
      end
   end

   assign req_stall        = busy;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;
   assign rsp_clipped      = rsp_clip_ff;

endmodule

`default_nettype wire

// ===== verif/agam_mix_checker.sv =====
`timescale 1ns / 100ps

module agam_mix_checker
   import agam_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic [SAMPLE_W-1:0]        req_ch0_sample,
   input  wire logic [SAMPLE_W-1:0]        req_ch1_sample,
   input  wire logic [SAMPLE_W-1:0]        req_ch2_sample,
   input  wire logic [SAMPLE_W-1:0]        req_ch3_sample,
   input  wire logic [SAMPLE_W-1:0]        req_ch4_sample,
   input  wire logic [SAMPLE_W-1:0]        req_ch5_sample,
   input  wire logic [SAMPLE_W-1:0]        req_ch6_sample,
   input  wire logic [SAMPLE_W-1:0]        req_ch7_sample,
   input  wire logic [COUNT_W-1:0]         req_channel_count,
   input  wire logic                       req_frame_end,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [SAMPLE_W-1:0]        rsp_mixed_sample,
   input  wire logic                       rsp_clipped,
   input  wire logic                       csr_write_en,
   input  wire logic [SHIFT_W-1:0]         csr_write_data,
   output int                              mismatches,
   output int                              outstanding,
   output int                              clip_total
);

   localparam int GAIN_FRAC = 16;
   localparam int GAIN_W    = GAIN_FRAC + 1;
   localparam int ACC_W     = SUM_W + 2;
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mixed;
      logic                clipped;
   } mix_out_type;

   mix_out_type         expected_mix[$];
   logic [GAIN_W-1:0]   gain;
   logic [SHIFT_W-1:0]  shift;
   int                  fail_count = 0;
   int                  clip_count = 0;
   int                  pending = 0;

   logic [CHANNELS-1:0][SAMPLE_W-1:0] lanes;

   assign lanes = {req_ch7_sample, req_ch6_sample, req_ch5_sample, req_ch4_sample,
                   req_ch3_sample, req_ch2_sample, req_ch1_sample, req_ch0_sample};

   assign mismatches  = fail_count;
   assign outstanding = pending;
   assign clip_total  = clip_count;

   task automatic report(input string what, input logic [SAMPLE_W-1:0] got,
                         input logic [SAMPLE_W-1:0] want);
      fail_count++;
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
   endtask

   function automatic void mix_and_scale(input logic [CHANNELS-1:0][SAMPLE_W-1:0] lane,
                                         input logic [COUNT_W-1:0] count,
                                         input logic last);
      logic signed [ACC_W-1:0] sum;
      logic [ACC_W-1:0]        mag;
      logic [47:0]             scaled;
      int                      active;
      mix_out_type             res;
      sum = '0;
      active = (count > COUNT_W'(CHANNELS)) ? CHANNELS : int'(count);
      for (int i = 0; i < active; i++)
         sum += ACC_W'($signed(lane[i]));
      mag = (sum < 0) ? ACC_W'(-sum) : ACC_W'(sum);
      scaled = (48'(mag) * 48'(gain)) >> GAIN_FRAC;
      res.clipped = 1'b0;
      if (sum >= 0 && scaled > 48'(OUT_MAX)) begin
         gain = GAIN_W'((48'(OUT_MAX) << GAIN_FRAC) / scaled);
         res.mixed = OUT_MAX;
         res.clipped = 1'b1;
      end else if (sum < 0 && scaled > 48'(OUT_MIN_MAG)) begin
         gain = GAIN_W'((48'(OUT_MIN_MAG) << GAIN_FRAC) / scaled);
         res.mixed = OUT_MIN_MAG;
         res.clipped = 1'b1;
      end else begin
         res.mixed = (sum < 0) ? -scaled[SAMPLE_W-1:0] : scaled[SAMPLE_W-1:0];
      end
      if (gain < GAIN_ONE)
         gain = gain + ((GAIN_ONE - gain) >> shift);
      if (last)
         gain = GAIN_ONE;
      if (res.clipped)
         clip_count++;
      expected_mix.push_back(res);
   endfunction

   always @(posedge clock) begin
      mix_out_type want;
      if (reset) begin
         gain = GAIN_ONE;
         shift = SHIFT_RESET;
         expected_mix.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_mix.size() == 0) begin
               report("result with no item pending", rsp_mixed_sample, '0);
            end else begin
               want = expected_mix.pop_front();
               if (rsp_mixed_sample !== want.mixed)
                  report("mixed_sample", rsp_mixed_sample, want.mixed);
               if (rsp_clipped !== want.clipped)
                  report("clipped", SAMPLE_W'(rsp_clipped), SAMPLE_W'(want.clipped));
            end
         end
         if (req_valid && !req_stall)
            mix_and_scale(lanes, req_channel_count, req_frame_end);
         if (csr_write_en)
            shift = csr_write_data;
      end
      pending <= expected_mix.size();
   end

endmodule

// ===== verif/tb_adaptive_gain_audio_mixer.sv =====
`timescale 1ns / 100ps

module tb_adaptive_gain_audio_mixer
   import agam_pkg::*;
();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 200;
   localparam int HOLD_OFF     = 300;
   localparam int HOLD_AT      = 150;

   typedef enum int {
      LEVEL_FULL,
      LEVEL_QUIET,
      LEVEL_HOT_POS,
      LEVEL_HOT_NEG,
      LEVEL_EDGE
   } level_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   wire logic             req_stall;
   logic [SAMPLE_W-1:0]   req_ch0_sample;
   logic [SAMPLE_W-1:0]   req_ch1_sample;
   logic [SAMPLE_W-1:0]   req_ch2_sample;
   logic [SAMPLE_W-1:0]   req_ch3_sample;
   logic [SAMPLE_W-1:0]   req_ch4_sample;
   logic [SAMPLE_W-1:0]   req_ch5_sample;
   logic [SAMPLE_W-1:0]   req_ch6_sample;
   logic [SAMPLE_W-1:0]   req_ch7_sample;
   logic [COUNT_W-1:0]    req_channel_count;
   logic                  req_frame_end;
   wire logic             rsp_valid;
   logic                  rsp_stall;
   wire logic [SAMPLE_W-1:0] rsp_mixed_sample;
   wire logic             rsp_clipped;
   logic                  csr_write_en;
   logic [SHIFT_W-1:0]    csr_write_data;
   int                    mismatches;
   int                    outstanding;
   int                    clip_total;

   int sent = 0;
   int taken = 0;
   int shifts_used = 0;
   int cycle_count = 0;

   adaptive_gain_audio_mixer uut (.*);

   agam_mix_checker mix_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count, outstanding);
         $display("FAIL adaptive_gain_audio_mixer");
         $finish;
      end
   end

   function automatic logic [SAMPLE_W-1:0] pick_level(input level_type level);
      logic [SAMPLE_W-1:0] v;
      case (level)
         LEVEL_QUIET: v = SAMPLE_W'($urandom_range(0, 1023)) - 16'd512;
         LEVEL_HOT_POS: v = SAMPLE_W'($urandom_range(24000, 32767));
         LEVEL_HOT_NEG: v = -SAMPLE_W'($urandom_range(24000, 32768));
         LEVEL_EDGE: begin
            case ($urandom_range(0, 3))
               0: v = OUT_MAX;
               1: v = OUT_MIN_MAG;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = SAMPLE_W'($urandom);
      endcase
      return v;
   endfunction

   task automatic offer(input logic [CHANNELS-1:0][SAMPLE_W-1:0] lanes,
                        input logic [COUNT_W-1:0] count, input logic last);
      int gap;
      gap = ((sent / 40) % 5 == 3) ? 0 : int'($urandom_range(0, 7));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch0_sample    <= lanes[0];
      req_ch1_sample    <= lanes[1];
      req_ch2_sample    <= lanes[2];
      req_ch3_sample    <= lanes[3];
      req_ch4_sample    <= lanes[4];
      req_ch5_sample    <= lanes[5];
      req_ch6_sample    <= lanes[6];
      req_ch7_sample    <= lanes[7];
      req_channel_count <= count;
      req_frame_end     <= last;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic set_shift(input logic [SHIFT_W-1:0] value);
      settle();
      csr_write_data <= value;
      csr_write_en <= 1'b1;
      @(negedge clock);
      csr_write_en <= 1'b0;
      shifts_used++;
   endtask

   task automatic run_frames(input int items);
      logic [CHANNELS-1:0][SAMPLE_W-1:0] lanes;
      logic [COUNT_W-1:0] count;
      level_type level;
      int frame_items;
      int left;
      int r;
      left = items;
      while (left > 0) begin
         frame_items = $urandom_range(1, 24);
         level = level_type'($urandom_range(0, 4));
         for (int k = 0; k < frame_items && left > 0; k++) begin
            for (int c = 0; c < CHANNELS; c++)
               lanes[c] = pick_level(($urandom_range(0, 9) == 0) ?
                                     level_type'($urandom_range(0, 4)) : level);
            r = $urandom_range(0, 19);
            if (r == 0)
               count = '0;
            else if (r == 1)
               count = COUNT_W'($urandom_range(9, 15));
            else
               count = COUNT_W'($urandom_range(1, 8));
            offer(lanes, count, (k == frame_items - 1) || ($urandom_range(0, 63) == 0));
            left--;
         end
      end
   endtask

   // receiver: random hold per item, one long hold-off to back the block up
   initial begin : sink
      int hold;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (taken == HOLD_AT)
            hold = HOLD_OFF;
         else if ((taken / 40) % 5 == 1)
            hold = 0;
         else
            hold = $urandom_range(0, 7);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [SHIFT_W-1:0] phase_shift;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ch0_sample = '0;
      req_ch1_sample = '0;
      req_ch2_sample = '0;
      req_ch3_sample = '0;
      req_ch4_sample = '0;
      req_ch5_sample = '0;
      req_ch6_sample = '0;
      req_ch7_sample = '0;
      req_channel_count = '0;
      req_frame_end = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      offer({CHANNELS{16'h1234}}, 4'd0, 1'b0);
      offer({CHANNELS{OUT_MAX}}, 4'd8, 1'b0);
      offer({112'd0, 16'd100}, 4'd1, 1'b0);
      offer({CHANNELS{OUT_MIN_MAG}}, 4'd8, 1'b0);
      offer({CHANNELS{OUT_MAX}}, 4'd15, 1'b1);
      offer({112'd0, OUT_MIN_MAG}, 4'd1, 1'b0);
      offer({112'd0, OUT_MAX}, 4'd1, 1'b0);
      offer({96'd0, 16'd1, OUT_MAX}, 4'd2, 1'b0);
      offer({96'd0, 16'hFFFF, OUT_MIN_MAG}, 4'd2, 1'b1);
      offer({4{OUT_MIN_MAG, OUT_MAX}}, 4'd8, 1'b0);
      offer({112'd0, 16'd20000}, 4'd1, 1'b0);
      offer({CHANNELS{16'h4000}}, 4'd9, 1'b0);
      set_shift(4'd0);
      offer({CHANNELS{16'h6000}}, 4'd8, 1'b0);
      offer({112'd0, 16'd30000}, 4'd1, 1'b0);
      set_shift(4'd15);
      offer({CHANNELS{16'hA000}}, 4'd8, 1'b0);
      offer({112'd0, 16'd1000}, 4'd1, 1'b0);
      offer({112'd0, 16'd1000}, 4'd1, 1'b0);
      offer({112'd0, 16'd1000}, 4'd1, 1'b1);
      offer({CHANNELS{16'hFFFF}}, 4'd8, 1'b1);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: phase_shift = 4'd1;
            1: phase_shift = 4'd15;
            2: phase_shift = 4'd0;
            3: phase_shift = SHIFT_RESET;
            default: phase_shift = SHIFT_W'($urandom_range(0, 15));
         endcase
         set_shift(phase_shift);
         run_frames(PHASE_ITEMS);
      end

      settle();
      repeat (40) @(negedge clock);

      $display("mixed %0d items under %0d recovery shift settings, %0d of them clipped",
               sent, shifts_used + 1, clip_total);
      $display("receiver held off %0d cycles once with the sender still offering", HOLD_OFF);
      if (mismatches == 0)
         $display("PASS adaptive_gain_audio_mixer");
      else
         $display("FAIL adaptive_gain_audio_mixer");
      $finish;
   end

endmodule
